[sv/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions for the string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // most bytes one request can produce: "\u" plus three held digits plus one byte
  localparam int unsigned BurstMax = 6;
  localparam int unsigned BurstCntW = 3;

  // character codes
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  // utf-8 encoding constants
  localparam logic [15:0] Utf8Lim1 = 16'h0080;
  localparam logic [15:0] Utf8Lim2 = 16'h0800;
  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;

  // one decoded burst of result bytes, slot 0 goes out first
  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [BurstCntW-1:0]     cnt;
    logic                     bad;
    logic                     fin;
  } burst_t;

  // true for 0-9, a-f, A-F
  function automatic logic is_hex(input logic [7:0] b);
    is_hex = ((b >= 8'h30) && (b <= 8'h39)) ||
             ((b >= 8'h61) && (b <= 8'h66)) ||
             ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  // nibble value of a hex digit, only meaningful when is_hex holds
  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    if (b[6]) begin
      hex_nib = b[3:0] + 4'd9;
    end else begin
      hex_nib = b[3:0];
    end
  endfunction

endpackage

[sv/jsu_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_parser
// Input register, escape parse state and single-pass decode of one request
// into a burst of up to six result bytes.
// ----------------------------------------------------------------------------
module jsu_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            burst_free_i,
  output logic            burst_load_o,
  output jsu_pkg::burst_t burst_o
);

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2
  } mode_e;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        accept;
  logic        move;

  mode_e       mode_q, mode_d;
  logic [1:0]  dc_q, dc_d;
  logic [11:0] acc_q, acc_d;
  logic [7:0]  held_q [3];
  logic        held_we;

  logic [jsu_pkg::BurstMax-1:0][7:0] dec_bytes;
  logic [jsu_pkg::BurstCntW-1:0]     dec_cnt;
  logic        dec_err;
  logic        esc_start;
  logic        b_hex;
  logic [3:0]  b_nib;
  logic [15:0] cp;

  // request moves on when the burst stage can take it or it yields nothing
  assign move       = in_vld_q && (burst_free_i || (dec_cnt == '0));
  assign in_stall_o = in_vld_q && !move;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_vld_d   = accept ? 1'b1 : (move ? 1'b0 : in_vld_q);

  assign esc_start = (in_byte_q == jsu_pkg::ChBslash) && !in_last_q;
  assign b_hex     = jsu_pkg::is_hex(in_byte_q);
  assign b_nib     = jsu_pkg::hex_nib(in_byte_q);
  assign cp        = {acc_q, b_nib};

  // decode of the held request against the parse state
  always_comb begin
    dec_bytes = {jsu_pkg::BurstMax{in_byte_q}};
    dec_cnt   = '0;
    dec_err   = 1'b0;
    mode_d    = mode_q;
    dc_d      = dc_q;
    acc_d     = acc_q;
    held_we   = 1'b0;
    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_TEXT;
        if (in_byte_q == jsu_pkg::ChLowN) begin
          dec_bytes[0] = jsu_pkg::ChLf;
          dec_cnt      = 3'd1;
        end else if (in_byte_q == jsu_pkg::ChLowT) begin
          dec_bytes[0] = jsu_pkg::ChTab;
          dec_cnt      = 3'd1;
        end else if (in_byte_q == jsu_pkg::ChLowR) begin
          dec_bytes[0] = jsu_pkg::ChCr;
          dec_cnt      = 3'd1;
        end else if ((in_byte_q == jsu_pkg::ChBslash) ||
                     (in_byte_q == jsu_pkg::ChQuote)) begin
          dec_cnt = 3'd1;
        end else if ((in_byte_q == jsu_pkg::ChLowU) && !in_last_q) begin
          mode_d = MODE_HEX;
          dc_d   = '0;
          acc_d  = '0;
        end else begin
          dec_bytes[0] = jsu_pkg::ChBslash;
          dec_cnt      = 3'd2;
        end
      end
      MODE_HEX: begin
        // literal replay: backslash, u, held digits, then the current byte unless it opens a new escape
        dec_bytes[0] = jsu_pkg::ChBslash;
        dec_bytes[1] = jsu_pkg::ChLowU;
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < dc_q) begin
            dec_bytes[k+2] = held_q[k];
          end
        end
        if (in_last_q && (dc_q != 2'd3)) begin
          dec_cnt = {1'b0, dc_q} + 3'd3;
          mode_d  = MODE_TEXT;
        end else if (!b_hex) begin
          dec_err = 1'b0 | 1'b1;
          if (esc_start) begin
            dec_cnt = {1'b0, dc_q} + 3'd2;
            mode_d  = MODE_ESC;
          end else begin
            dec_cnt = {1'b0, dc_q} + 3'd3;
            mode_d  = MODE_TEXT;
          end
        end else if (dc_q == 2'd3) begin
          mode_d = MODE_TEXT;
          if (cp < jsu_pkg::Utf8Lim1) begin
            dec_bytes[0] = cp[7:0];
            dec_cnt      = 3'd1;
          end else if (cp < jsu_pkg::Utf8Lim2) begin
            dec_bytes[0] = jsu_pkg::Utf8Lead2 | {3'b000, cp[10:6]};
            dec_bytes[1] = jsu_pkg::Utf8Cont | {2'b00, cp[5:0]};
            dec_cnt      = 3'd2;
          end else begin
            dec_bytes[0] = jsu_pkg::Utf8Lead3 | {4'h0, cp[15:12]};
            dec_bytes[1] = jsu_pkg::Utf8Cont | {2'b00, cp[11:6]};
            dec_bytes[2] = jsu_pkg::Utf8Cont | {2'b00, cp[5:0]};
            dec_cnt      = 3'd3;
          end
        end else begin
          held_we = 1'b1;
          dc_d    = dc_q + 2'd1;
          acc_d   = {acc_q[7:0], b_nib};
        end
        if (mode_d != MODE_HEX) begin
          dc_d  = '0;
          acc_d = '0;
        end
      end
      default: begin
        // normal text, also the unused mode code
        if (esc_start) begin
          mode_d = MODE_ESC;
        end else begin
          mode_d  = MODE_TEXT;
          dec_cnt = 3'd1;
        end
      end
    endcase
    // end of string returns mode, digit count and accumulator to their idle values
    if (in_last_q) begin
      mode_d = MODE_TEXT;
      dc_d   = '0;
      acc_d  = '0;
    end
  end

  assign burst_load_o  = move && (dec_cnt != '0);
  assign burst_o.bytes = dec_bytes;
  assign burst_o.cnt   = dec_cnt;
  assign burst_o.bad   = dec_err;
  assign burst_o.fin   = in_last_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_TEXT;
      dc_q     <= '0;
      acc_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (move) begin
        mode_q <= mode_d;
        dc_q   <= dc_d;
        acc_q  <= acc_d;
      end
    end
  end

  // input payload and held digits
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    if (move && held_we) begin
      held_q[dc_q] <= in_byte_q;
    end
  end

endmodule

[sv/jsu_burst_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_burst_out
// Result register holding one decoded burst, shifted out one byte per
// request on the output channel.
// ----------------------------------------------------------------------------
module jsu_burst_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            burst_load_i,
  input  jsu_pkg::burst_t burst_i,
  output logic            burst_free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            text_end_o,
  output logic            bad_hex_o
);

  logic [jsu_pkg::BurstMax-1:0][7:0] bytes_q;
  logic [jsu_pkg::BurstCntW-1:0]     rem_q;
  logic                              bad_q;
  logic                              fin_q;
  logic                              take;

  assign take         = out_valid_o && !out_stall_i;
  assign out_valid_o  = (rem_q != '0);
  assign burst_free_o = (rem_q == '0) || ((rem_q == 3'd1) && !out_stall_i);

  assign out_byte_o = bytes_q[0];
  assign run_last_o = (rem_q == 3'd1);
  assign text_end_o = fin_q && (rem_q == 3'd1);
  assign bad_hex_o  = bad_q;

  // remaining count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (burst_load_i) begin
      rem_q <= burst_i.cnt;
    end else if (take) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  // burst payload, shifts toward slot 0 as bytes are taken
  always_ff @(posedge clk_i) begin
    if (burst_load_i) begin
      bytes_q <= burst_i.bytes;
      bad_q   <= burst_i.bad;
      fin_q   <= burst_i.fin;
    end else if (take) begin
      bytes_q <= bytes_q >> 8;
    end
  end

endmodule

[sv/json_string_unescape_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Streaming unescaper for the body of a JSON string, one byte per request.
// ----------------------------------------------------------------------------
// A request enters an input register, is decoded combinationally against the
// escape state and yields 0 to 6 bytes; a non-empty burst lands in a result
// register, which sends one byte per cycle while out_stall_i is low, so plain
// text streams at that rate. Input and result register lie in turn between
// acceptance and the first result byte. A longer burst holds the result
// register until its last byte is taken; requests with bytes wait behind it.
// A held \u escape is replayed literally when the string ends early or a
// non-hex byte arrives; in the latter case bad_hex_o is set on the whole burst.
module json_string_unescape_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_end_o,
  output logic       bad_hex_o
);

  logic            burst_free;
  logic            burst_load;
  jsu_pkg::burst_t burst;

  // parse and decode
  jsu_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .burst_free_i (burst_free),
    .burst_load_o (burst_load),
    .burst_o      (burst)
  );

  // result register and serializer
  jsu_burst_out u_burst_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .burst_load_i (burst_load),
    .burst_i      (burst),
    .burst_free_o (burst_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .text_end_o   (text_end_o),
    .bad_hex_o    (bad_hex_o)
  );

endmodule

[sv/jsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       text_end_o,
  input logic       bad_hex_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(run_last_o) && $stable(text_end_o) && $stable(bad_hex_o))
    else $error("stalled result changed");

  // end of string only on the last byte of a burst
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_end_o |-> run_last_o)
    else $error("text end without run last");

  // a burst continues, with the same error flag, after a taken byte that is not its last
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=>
    out_valid_o && (bad_hex_o == $past(bad_hex_o)))
    else $error("burst broken or error flag changed mid burst");

  // a stalled request only waits behind a pending result
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .run_last_o  (run_last_o),
  .text_end_o  (text_end_o),
  .bad_hex_o   (bad_hex_o)
);
